>>> design/sound_level_meter_unit_assert.svh
// ----------------------------------------------------------------------------
// Sound level meter assertion macros
// Shared property forms for the checker of the sound level meter unit.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_METER_UNIT_ASSERT_SVH
`define SOUND_LEVEL_METER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define SLM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sound level meter: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define SLM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sound level meter: next-cycle check failed");

`endif

>>> design/slm_pkg.sv
// ----------------------------------------------------------------------------
// Sound level meter package
// Widths, word types, register codes and the log2 fraction table.
// ----------------------------------------------------------------------------
package slm_pkg;

	localparam int BLOCK_SAMPLES  = 1024;
	localparam int LOG_TABLE_BITS = 6;
	localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;

	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 2 * SAMPLE_W - 1;
	localparam int SUM_W    = 46;
	localparam int LVL_W    = 11;
	localparam int CAL_W    = 12;
	localparam int POS_W    = $clog2(SUM_W);
	localparam int GROUPS   = (SUM_W + 7) / 8;
	localparam int GRP_W    = $clog2(GROUPS);
	localparam int FRAC_W   = 16;
	localparam int D_W      = 24;
	localparam int PROD_W   = 2 * D_W;
	localparam int T_W      = 50;
	localparam int LVLS_W   = T_W - 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 2;

	localparam logic signed [CAL_W-1:0] CAL_RESET      = 12'sd427;
	localparam logic [LVL_W-1:0]        NOISE_RESET    = 11'd464;
	localparam logic [LVL_W-1:0]        OVERLOAD_RESET = 11'd1920;
	localparam logic signed [D_W-1:0]   DB_SCALE       = 24'sd3156542;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CALIBRATION = 2'd0,
		CFG_NOISE_FLOOR = 2'd1,
		CFG_OVERLOAD    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
		logic                       clear_extremes;
	} slm_in_t;

	typedef struct packed {
		logic [LVL_W-1:0]        level;
		logic [LVL_W-1:0]        max_level;
		logic [LVL_W-1:0]        min_level;
		logic                    in_window;
		logic signed [CAL_W-1:0] raw_level;
	} slm_out_t;

	typedef struct packed {
		logic signed [CAL_W-1:0] calibration_offset;
		logic [LVL_W-1:0]        noise_floor;
		logic [LVL_W-1:0]        overload_level;
	} slm_cfg_t;

	// Work handed from the accumulator to the level path.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             blk;
		logic             clr;
	} slm_entry_t;

	typedef struct packed {
		logic vld;
		logic blk;
		logic clr;
		logic zero;
	} slm_ctl_t;

	typedef logic [TABLE_SIZE-1:0][FRAC_W-1:0] frac_tab_t;

	// log2(1 + i/TABLE_SIZE) in Q16 by repeated squaring, truncated.
	function automatic frac_tab_t build_frac_table();
		frac_tab_t   tab;
		logic [63:0] x;
		logic [15:0] f;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
			f = '0;
			for (int r = 0; r < 16; r++) begin
				x = (x * x) >> 30;
				f = {f[14:0], 1'b0};
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					f[0] = 1'b1;
				end
			end
			tab[i] = f;
		end
		return tab;
	endfunction

	localparam frac_tab_t FRAC_TABLE = build_frac_table();

	function automatic int log2_q16_const(int unsigned v);
		int          p;
		int unsigned idx;
		p = 0;
		for (int k = 0; k < 32; k++) begin
			if ((v >> k) != 0)
				p = k;
		end
		if (p >= LOG_TABLE_BITS)
			idx = (v >> (p - LOG_TABLE_BITS)) & (TABLE_SIZE - 1);
		else
			idx = (v << (LOG_TABLE_BITS - p)) & (TABLE_SIZE - 1);
		return p * 65536 + int'(FRAC_TABLE[idx]);
	endfunction

	localparam logic signed [D_W-1:0] LOG_BLOCK_Q16 = D_W'(log2_q16_const(BLOCK_SAMPLES));

endpackage

>>> design/slm_front.sv
// ----------------------------------------------------------------------------
// Sound level meter front end
// Squares samples, keeps the saturating block sum and queues block ends
// and clear requests for the level path.
// ----------------------------------------------------------------------------
module slm_front
	import slm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       smp_valid,
	input  slm_in_t    smp_data,
	output logic       smp_stall,
	output logic       push,
	output slm_entry_t push_data,
	input  logic       q_full
);

	logic                  vld_s1;
	logic [SQ_W-1:0]       sq_s1;
	logic                  last_s1;
	logic                  clr_s1;
	logic [SUM_W-1:0]      sum_q;

	logic [SAMPLE_W-1:0]   mag;
	logic [2*SAMPLE_W-1:0] sq_full;
	logic [SUM_W:0]        sum_wide;
	logic [SUM_W-1:0]      sum_sat;
	logic                  need;
	logic                  hold;

	assign mag      = smp_data.sample[SAMPLE_W-1] ? (~smp_data.sample + 1'b1) : smp_data.sample;
	assign sq_full  = mag * mag;
	assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(sq_s1);
	assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

	assign need      = last_s1 || clr_s1;
	assign hold      = vld_s1 && need && q_full;
	assign smp_stall = hold;

	assign push           = vld_s1 && need && !q_full;
	assign push_data.sum  = sum_sat;
	assign push_data.blk  = last_s1;
	assign push_data.clr  = clr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sum_q  <= '0;
		end else if (!hold) begin
			vld_s1 <= smp_valid;
			// restart the sum after a block end
			if (vld_s1)
				sum_q <= last_s1 ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && smp_valid) begin
			sq_s1   <= sq_full[SQ_W-1:0];
			last_s1 <= smp_data.block_end;
			clr_s1  <= smp_data.clear_extremes;
		end
	end

endmodule

>>> design/slm_fifo.sv
// ----------------------------------------------------------------------------
// Sound level meter queue
// Short first-in first-out queue between the accumulator and level path.
// ----------------------------------------------------------------------------
module slm_fifo
	import slm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  slm_entry_t push_data,
	input  logic       pop,
	output slm_entry_t pop_data,
	output logic       full,
	output logic       empty
);

	slm_entry_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> design/slm_back.sv
// ----------------------------------------------------------------------------
// Sound level meter level path
// Turns a block sum into a level in 1/16 dB, applies the window and keeps
// the stored, highest and lowest levels.
// ----------------------------------------------------------------------------
module slm_back
	import slm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  slm_cfg_t   cfg,
	input  logic       q_empty,
	input  slm_entry_t q_data,
	output logic       pop,
	output logic       res_valid,
	output slm_out_t   res_data,
	input  logic       res_stall
);

	slm_ctl_t                  ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [SUM_W-1:0]          sum_s1, sum_s2;
	logic [GROUPS-1:0]         nz_s1;
	logic [2:0]                lp_s1 [GROUPS];
	logic [POS_W-1:0]          p_s2, p_s3;
	logic [LOG_TABLE_BITS-1:0] idx_s3;
	logic signed [D_W-1:0]     d_s4;
	logic signed [PROD_W-1:0]  prod_s5;
	logic signed [LVLS_W-1:0]  lvl_s6;

	logic [LVL_W-1:0]          stored_q, highest_q, lowest_q;
	logic                      res_valid_q;
	slm_out_t                  res_q;

	logic                      en;
	logic [8*GROUPS-1:0]       pad;
	logic [GROUPS-1:0]         nz;
	logic [2:0]                lp [GROUPS];
	logic [GRP_W-1:0]          grp;
	logic [SUM_W-1:0]          norm;
	logic signed [T_W-1:0]     t;
	logic                      ok;
	logic [LVL_W-1:0]          stored_nx, highest_nx, lowest_nx;
	logic signed [CAL_W-1:0]   raw;

	// advance the whole path unless a finished result is held
	assign en  = !res_valid_q || !res_stall;
	assign pop = en && !q_empty;

	// leading-one search, first pass: per-byte position
	always_comb begin
		pad = (8*GROUPS)'(q_data.sum);
		for (int g = 0; g < GROUPS; g++) begin
			nz[g] = |pad[g*8 +: 8];
			lp[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (pad[g*8 + b])
					lp[g] = 3'(b);
			end
		end
	end

	// second pass: highest nonzero byte
	always_comb begin
		grp = '0;
		for (int g = 0; g < GROUPS; g++) begin
			if (nz_s1[g])
				grp = GRP_W'(g);
		end
	end

	assign norm = sum_s2 << (POS_W'(SUM_W - 1) - p_s2);

	assign t = T_W'(prod_s5)
		+ $signed({cfg.calibration_offset, 32'b0})
		+ $signed(T_W'(64'd1 << 31));

	always_comb begin
		ok = !ctl_s6.zero
			&& (lvl_s6 >= $signed({{(LVLS_W-LVL_W){1'b0}}, cfg.noise_floor}))
			&& (lvl_s6 <= $signed({{(LVLS_W-LVL_W){1'b0}}, cfg.overload_level}));
		stored_nx  = stored_q;
		highest_nx = highest_q;
		lowest_nx  = lowest_q;
		if (ctl_s6.blk && ok) begin
			stored_nx = lvl_s6[LVL_W-1:0];
			if (stored_nx > highest_q)
				highest_nx = stored_nx;
			if (stored_nx < lowest_q)
				lowest_nx = stored_nx;
		end
		if (ctl_s6.clr) begin
			highest_nx = stored_nx;
			lowest_nx  = stored_nx;
		end
		priority if (ctl_s6.zero)
			raw = {1'b1, {(CAL_W-1){1'b0}}};
		else if (lvl_s6 > LVLS_W'($signed(12'sd2047)))
			raw = 12'sd2047;
		else if (lvl_s6 < LVLS_W'($signed(-12'sd2048)))
			raw = -12'sd2048;
		else
			raw = lvl_s6[CAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			ctl_s5      <= '0;
			ctl_s6      <= '0;
			stored_q    <= '0;
			highest_q   <= '0;
			lowest_q    <= '1;
			res_valid_q <= 1'b0;
		end else if (en) begin
			ctl_s1.vld  <= !q_empty;
			ctl_s1.blk  <= q_data.blk;
			ctl_s1.clr  <= q_data.clr;
			ctl_s1.zero <= ~|q_data.sum;
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			ctl_s5      <= ctl_s4;
			ctl_s6      <= ctl_s5;
			if (ctl_s6.vld) begin
				stored_q  <= stored_nx;
				highest_q <= highest_nx;
				lowest_q  <= lowest_nx;
			end
			res_valid_q <= ctl_s6.vld && ctl_s6.blk;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= q_data.sum;
			nz_s1   <= nz;
			lp_s1   <= lp;
			sum_s2  <= sum_s1;
			p_s2    <= POS_W'({grp, lp_s1[grp]});
			p_s3    <= p_s2;
			idx_s3  <= norm[SUM_W-2 -: LOG_TABLE_BITS];
			d_s4    <= $signed({2'b0, p_s3, FRAC_TABLE[idx_s3]}) - LOG_BLOCK_Q16;
			prod_s5 <= d_s4 * DB_SCALE;
			lvl_s6  <= t[T_W-1:32];
			res_q.level     <= stored_nx;
			res_q.max_level <= highest_nx;
			res_q.min_level <= lowest_nx;
			res_q.in_window <= ok;
			res_q.raw_level <= raw;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> design/sound_level_meter_unit.sv
// ----------------------------------------------------------------------------
// Sound level meter unit
// Block RMS level in 1/16 dB with noise-floor and overload window.
// ----------------------------------------------------------------------------
// The unit takes one sample word per clock while it does not stall. The
// front end squares it, registers the square and then adds it to the
// block sum; a block end or a clear request goes into a four-entry queue.
// The level path takes one queue entry per clock while its result is not
// held and returns the block's result word through stages s1 to s6 and the
// result register. Samples stall only when the result port is held long
// enough for the queue to fill; the path itself never limits the rate.
// Configuration writes are always taken (cfg_ready is high) and are meant
// to happen while the unit is idle. There is no clearing pass after reset.
module sound_level_meter_unit
	import slm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  smp_valid,
	input  slm_in_t               smp_data,
	output logic                  smp_stall,
	output logic                  res_valid,
	output slm_out_t              res_data,
	input  logic                  res_stall,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CAL_W-1:0]      cfg_data
);

	slm_cfg_t   cfg_q;
	logic       push;
	slm_entry_t push_data;
	logic       pop;
	slm_entry_t pop_data;
	logic       q_full;
	logic       q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calibration_offset <= CAL_RESET;
			cfg_q.noise_floor        <= NOISE_RESET;
			cfg_q.overload_level     <= OVERLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CALIBRATION: cfg_q.calibration_offset <= cfg_data;
				CFG_NOISE_FLOOR: cfg_q.noise_floor        <= cfg_data[LVL_W-1:0];
				CFG_OVERLOAD:    cfg_q.overload_level     <= cfg_data[LVL_W-1:0];
				// drop writes to unknown registers
				default: ;
			endcase
		end
	end

	slm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_data  (smp_data),
		.smp_stall (smp_stall),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	slm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	slm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_stall (res_stall)
	);

endmodule

>>> design/slm_checker.sv
// ----------------------------------------------------------------------------
// Sound level meter checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "sound_level_meter_unit_assert.svh"

module slm_checker
	import slm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input slm_out_t             res_data,
	input logic                 res_stall
);

	logic accepted_ok;
	logic extremes_ok;
	logic fresh_ok;

	// an accepted level is the stored one and lies between min and max
	assign accepted_ok = !res_data.raw_level[CAL_W-1]
		&& (res_data.level == res_data.raw_level[LVL_W-1:0])
		&& (res_data.min_level <= res_data.level)
		&& (res_data.level <= res_data.max_level);

	// max below min only while nothing was accepted or cleared since reset
	assign extremes_ok = (res_data.max_level == '0) && (res_data.min_level == '1);

	// before any block was accepted, the stored level is still zero
	assign fresh_ok = (res_data.level == '0);

	`SLM_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(res_data))
	`SLM_ASSERT_IMP(a_accepted, clk, arst_n, res_valid && res_data.in_window, accepted_ok)
	`SLM_ASSERT_IMP(a_extremes, clk, arst_n,
		res_valid && (res_data.max_level < res_data.min_level), extremes_ok)
	`SLM_ASSERT_IMP(a_fresh, clk, arst_n,
		res_valid && (res_data.max_level < res_data.min_level), fresh_ok)

endmodule

bind sound_level_meter_unit slm_checker u_slm_checker (.*);

>>> tb/sound_level_meter_unit_tb.sv
// ----------------------------------------------------------------------------
// Sound level meter unit testbench
// Drives sample words and register writes into the meter and checks every
// result word against an in-bench level predictor. A short table of directed
// words comes first. A long result-port hold fills the unit. Random blocks
// then run under a series of calibration and window settings, with random
// gaps on both ports.
// ----------------------------------------------------------------------------
module sound_level_meter_unit_tb;
	import slm_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int SETTLE       = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int ITEM_TARGET  = 800;
	localparam int BLOCK_TARGET = 60;
	localparam int PHASE_ITEMS  = 90;

	localparam logic [CFG_IDX_W-1:0]        CFG_SPARE   = 2'd3;
	localparam logic [CAL_W-1:0]            RAW_BOTTOM  = 12'h800;
	localparam logic [CAL_W-1:0]            RAW_TOP     = 12'h7FF;
	localparam logic signed [CAL_W-1:0]     CAL_LOWEST  = 12'sh800;
	localparam logic signed [CAL_W-1:0]     CAL_HIGHEST = 12'sh7FF;
	localparam logic [LVL_W-1:0]            LVL_TOP     = '1;
	localparam longint unsigned             ENERGY_CAP  = (64'd1 << SUM_W) - 64'd1;
	localparam logic signed [SAMPLE_W-1:0]  FULL_NEG    = 16'sh8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       last;
		logic                       clr;
		logic                       typed;
		slm_out_t                   want;
	} stim_row_t;

	localparam int OPENING_ROWS = 16;

	// Typed expectations only where the state is plain: right after reset
	// and after a clear, with a zero-energy block end.
	stim_row_t opening [OPENING_ROWS] = '{
		'{16'sd0,      1'b1, 1'b0, 1'b1, '{11'd0, 11'd0, LVL_TOP, 1'b0, RAW_BOTTOM}},
		'{16'sd0,      1'b0, 1'b1, 1'b0, '0},
		'{16'sd0,      1'b1, 1'b0, 1'b1, '{11'd0, 11'd0, 11'd0, 1'b0, RAW_BOTTOM}},
		'{16'sd1,      1'b1, 1'b0, 1'b0, '0},
		'{FULL_NEG,    1'b1, 1'b0, 1'b0, '0},
		'{16'sd32767,  1'b0, 1'b0, 1'b0, '0},
		'{16'sd32767,  1'b0, 1'b0, 1'b0, '0},
		'{16'sd32767,  1'b0, 1'b0, 1'b0, '0},
		'{16'sd32767,  1'b1, 1'b0, 1'b0, '0},
		'{-16'sd1,     1'b0, 1'b0, 1'b0, '0},
		'{16'sh5555,   1'b0, 1'b0, 1'b0, '0},
		'{16'shAAAA,   1'b1, 1'b1, 1'b0, '0},
		'{FULL_NEG,    1'b0, 1'b1, 1'b0, '0},
		'{16'sd0,      1'b1, 1'b0, 1'b0, '0},
		'{16'sd0,      1'b1, 1'b0, 1'b0, '0},
		'{-16'sd32767, 1'b1, 1'b0, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 smp_valid;
	slm_in_t              smp_data;
	logic                 smp_stall;
	logic                 res_valid;
	slm_out_t             res_data;
	logic                 res_stall = 1'b0;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0]     cfg_data;

	// Predictor state
	logic [FRAC_W-1:0]       log_frac_lut [TABLE_SIZE];
	logic signed [CAL_W-1:0] cal_offset;
	logic [LVL_W-1:0]        floor_lvl;
	logic [LVL_W-1:0]        ceil_lvl;
	longint unsigned         acc_energy;
	logic [LVL_W-1:0]        held_level;
	logic [LVL_W-1:0]        peak_level;
	logic [LVL_W-1:0]        trough_level;

	slm_out_t levels_due [$];
	bit       failed = 1'b0;
	bit       calm = 1'b0;
	bit       hold_req = 1'b0;
	int       random_items = 0;
	int       blocks_sent = 0;
	int       stall_left = 0;
	int       idle_cycles = 0;

	sound_level_meter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_data  (smp_data),
		.smp_stall (smp_stall),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_stall (res_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// log2(1 + i/TABLE_SIZE) in Q16: square a Q30 value, peel one bit per round.
	function automatic logic [FRAC_W-1:0] frac_log2(int i);
		logic [63:0]       x;
		logic [FRAC_W-1:0] f;
		x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
		f = '0;
		for (int r = 0; r < FRAC_W; r++) begin
			x = (x * x) >> 30;
			f = f << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				f[0] = 1'b1;
			end
		end
		return f;
	endfunction

	function automatic longint log2_fixed(longint unsigned v);
		int              lead;
		longint unsigned idx;
		lead = 0;
		for (int k = 1; k < 64; k++)
			if ((v >> k) != 0)
				lead = k;
		if (lead >= LOG_TABLE_BITS)
			idx = (v >> (lead - LOG_TABLE_BITS)) & (TABLE_SIZE - 1);
		else
			idx = (v << (LOG_TABLE_BITS - lead)) & (TABLE_SIZE - 1);
		return longint'(lead) * 65536 + longint'(log_frac_lut[idx]);
	endfunction

	// Advance the meter by one sample word; returns 1 when a result word is due.
	function automatic bit meter_predict(input slm_in_t w, output slm_out_t r);
		longint mag;
		longint span;
		longint t;
		longint lvl;
		bit     accepted;
		mag = longint'(w.sample);
		if (mag < 0)
			mag = -mag;
		accepted = 1'b0;
		r = '0;
		r.raw_level = RAW_BOTTOM;
		acc_energy += mag * mag;
		if (acc_energy > ENERGY_CAP)
			acc_energy = ENERGY_CAP;
		if (w.block_end) begin
			if (acc_energy != 0) begin
				span = log2_fixed(acc_energy) - log2_fixed(BLOCK_SAMPLES);
				t = span * longint'(DB_SCALE) + (longint'(cal_offset) <<< 32)
					+ 64'sd2147483648;
				lvl = t >>> 32;
				if (lvl >= longint'(floor_lvl) && lvl <= longint'(ceil_lvl)) begin
					accepted = 1'b1;
					held_level = lvl[LVL_W-1:0];
					if (held_level > peak_level)
						peak_level = held_level;
					if (held_level < trough_level)
						trough_level = held_level;
				end
				if (lvl > 2047)
					r.raw_level = RAW_TOP;
				else if (lvl < -2048)
					r.raw_level = RAW_BOTTOM;
				else
					r.raw_level = lvl[CAL_W-1:0];
			end
			acc_energy = 0;
		end
		if (w.clear_extremes) begin
			peak_level = held_level;
			trough_level = held_level;
		end
		r.level = held_level;
		r.max_level = peak_level;
		r.min_level = trough_level;
		r.in_window = accepted;
		return w.block_end;
	endfunction

	task automatic send_word(slm_in_t w, bit typed = 1'b0, slm_out_t want = '0);
		slm_out_t r;
		smp_valid <= 1'b1;
		smp_data <= w;
		@(negedge clk);
		while (smp_stall !== 1'b0)
			@(negedge clk);
		@(posedge clk);
		if (meter_predict(w, r))
			levels_due.push_back(typed ? want : r);
	endtask

	task automatic sender_gap();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (calm || pick < 70)
			n = 0;
		else if (pick < 95)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			smp_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_block();
		int                         len;
		int                         pick;
		int                         kind;
		int                         shift;
		logic signed [SAMPLE_W-1:0] s;
		slm_in_t                    w;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			len = $urandom_range(1, 8);
		else if (pick < 97)
			len = $urandom_range(9, 40);
		else
			len = $urandom_range(41, 200);
		shift = $urandom_range(0, SAMPLE_W - 1);
		// a few silent blocks and a few single full-scale words
		kind = $urandom_range(0, 99);
		if (kind >= 5 && kind < 8)
			len = 1;
		for (int n = 0; n < len; n++) begin
			s = SAMPLE_W'($urandom);
			s = s >>> shift;
			if (kind < 5)
				s = '0;
			else if (kind < 8)
				s = FULL_NEG;
			w.sample = s;
			w.block_end = (n == len - 1);
			w.clear_extremes = ($urandom_range(0, 15) == 0);
			send_word(w);
			random_items++;
			sender_gap();
		end
		blocks_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (cfg_ready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			CFG_CALIBRATION: cal_offset = val;
			CFG_NOISE_FLOOR: floor_lvl = val[LVL_W-1:0];
			CFG_OVERLOAD:    ceil_lvl = val[LVL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic signed [CAL_W-1:0] cal, logic [LVL_W-1:0] lo,
		logic [LVL_W-1:0] hi);
		write_reg(CFG_CALIBRATION, cal);
		write_reg(CFG_NOISE_FLOOR, {1'($urandom), lo});
		write_reg(CFG_OVERLOAD, {1'($urandom), hi});
		write_reg(CFG_SPARE, CAL_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Wait out pending results, then the level path's latency for clear-only words.
	task automatic drain();
		smp_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic compare_field(string name, logic [CAL_W-1:0] want, logic [CAL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Result port: random stalls, plus one long hold on request.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			res_stall <= 1'b1;
			stall_left = HOLD_CYCLES - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			res_stall <= 1'b1;
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 2);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Handshake signals are settled mid-cycle; a word seen here moves at the next edge.
	always @(negedge clk) begin : check_results
		slm_out_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (levels_due.size() == 0) begin
				$error("result word with no level pending: %0h", res_data);
				failed = 1'b1;
			end else begin
				want = levels_due.pop_front();
				compare_field("level", CAL_W'(want.level), CAL_W'(res_data.level));
				compare_field("max_level", CAL_W'(want.max_level), CAL_W'(res_data.max_level));
				compare_field("min_level", CAL_W'(want.min_level), CAL_W'(res_data.min_level));
				compare_field("in_window", CAL_W'(want.in_window), CAL_W'(res_data.in_window));
				compare_field("raw_level", want.raw_level, res_data.raw_level);
			end
		end
	end

	always @(negedge clk) begin
		if ((smp_valid === 1'b1 && smp_stall === 1'b0)
			|| (res_valid === 1'b1 && res_stall === 1'b0)
			|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** sound_level_meter_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		slm_in_t          w;
		slm_out_t         want;
		logic [LVL_W-1:0] lo;
		logic [LVL_W-1:0] hi;
		int               start;
		arst_n <= 1'b0;
		smp_valid <= 1'b0;
		smp_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		for (int i = 0; i < TABLE_SIZE; i++)
			log_frac_lut[i] = frac_log2(i);
		cal_offset = CAL_RESET;
		floor_lvl = NOISE_RESET;
		ceil_lvl = OVERLOAD_RESET;
		acc_energy = 0;
		held_level = '0;
		peak_level = '0;
		trough_level = LVL_TOP;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			w.sample = opening[i].smp;
			w.block_end = opening[i].last;
			w.clear_extremes = opening[i].clr;
			want = opening[i].want;
			send_word(w, opening[i].typed, want);
			sender_gap();
		end
		drain();

		// Hold the result port while one-word blocks keep coming; the queue fills.
		hold_req = 1'b1;
		repeat (40) begin
			w.sample = SAMPLE_W'($urandom);
			w.block_end = 1'b1;
			w.clear_extremes = ($urandom_range(0, 7) == 0);
			send_word(w);
		end
		drain();

		for (int ph = 0; random_items < ITEM_TARGET || blocks_sent < BLOCK_TARGET; ph++) begin
			calm = (ph % 3 == 2);
			case (ph)
				0: set_config(12'sd0, 11'd0, LVL_TOP);
				1: set_config(CAL_HIGHEST, 11'd0, LVL_TOP);
				2: set_config(CAL_LOWEST, 11'd0, LVL_TOP);
				3: set_config(CAL_RESET, 11'd1390, 11'd1390);
				4: set_config(CAL_RESET, OVERLOAD_RESET, NOISE_RESET);
				5: set_config(12'sd0, LVL_TOP, LVL_TOP);
				6: set_config(-12'sd100, 11'd0, 11'd0);
				default: begin
					lo = LVL_W'($urandom_range(0, 1200));
					hi = LVL_W'($urandom_range(lo, 2047));
					set_config(CAL_W'($urandom), lo, hi);
				end
			endcase
			start = random_items;
			while (random_items - start < PHASE_ITEMS)
				send_block();
			drain();
		end

		if (!failed)
			$display("** sound_level_meter_unit: PASSED **");
		else
			$display("** sound_level_meter_unit: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/slm_pkg.sv
design/slm_front.sv
design/slm_fifo.sv
design/slm_back.sv
design/sound_level_meter_unit.sv
design/slm_checker.sv
tb/sound_level_meter_unit_tb.sv
